// File: design/record_table_search_delete_defines.svh
// ----------------------------------------------------------------------------
// record_table_search_delete_defines.svh
// Assertion macros shared by the record table modules.
// ----------------------------------------------------------------------------
`ifndef RECORD_TABLE_SEARCH_DELETE_DEFINES_SVH
`define RECORD_TABLE_SEARCH_DELETE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RTSD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RTSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/rtsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsd_pkg
// Types and constants for the record table with search and delete.
// ----------------------------------------------------------------------------
package rtsd_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int HEAD_W       = 64;
	localparam int TAIL_W       = 8;
	localparam int AGE_W        = 8;
	localparam int HEIGHT_W     = 9;
	localparam int IN_DATA_W    = 96;
	localparam int OUT_DATA_W   = 96;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_LIST   = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_RECORD   = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_DELETED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_READ,
		S_TEST,
		S_END,
		S_SH_RD,
		S_SH_WR,
		S_PUT
	} state_t;

	// One table record, head in the low bits
	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic [AGE_W-1:0]    age;
		logic [TAIL_W-1:0]   tail;
		logic [HEAD_W-1:0]   head;
	} record_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    idx_clr;
		logic    idx_inc;
		logic    rd_en;
		logic    rd_next;
		logic    wr_ins;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    pend_load;
		logic    pend_clr;
		logic    push;
		logic    push_pend;
		status_t push_status;
		logic    push_last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic cnt_full;
		logic idx_last;
		logic shift_last;
		logic hit;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

// File: design/rtsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsd_ctrl
// Sequencer for the record table: dispatch, table sweep, delete compaction.
// ----------------------------------------------------------------------------
`include "record_table_search_delete_defines.svh"

module rtsd_ctrl import rtsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t  state_q, state_d;
	status_t stat_q, stat_d;

	// State and pending status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_EMPTY;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_START;
			end
			S_START: begin
				if (sts.op == OP_INSERT) begin
					stat_d  = sts.cnt_full ? ST_FULL : ST_INSERTED;
					state_d = S_PUT;
				end else if (sts.cnt_zero) begin
					stat_d  = ST_EMPTY;
					state_d = S_PUT;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: state_d = S_TEST;
			S_TEST: begin
				if (sts.op == OP_DELETE) begin
					if (sts.hit) begin
						if (sts.idx_last) begin
							stat_d  = ST_DELETED;
							state_d = S_PUT;
						end else begin
							state_d = S_SH_RD;
						end
					end else if (sts.idx_last) begin
						stat_d  = ST_NOTFOUND;
						state_d = S_PUT;
					end else begin
						state_d = S_READ;
					end
				end else if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
					state_d = sts.idx_last ? S_END : S_READ;
				end
			end
			S_END: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: begin
				if (sts.shift_last) begin
					stat_d  = ST_DELETED;
					state_d = S_PUT;
				end else begin
					state_d = S_SH_RD;
				end
			end
			S_PUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		cmd.push_status = stat_q;
		case (state_q)
			S_IDLE: cmd.capture = s_tvalid;
			S_START: begin
				if (sts.op == OP_INSERT) begin
					cmd.wr_ins  = !sts.cnt_full;
					cmd.cnt_inc = !sts.cnt_full;
				end else begin
					cmd.idx_clr = 1'b1;
				end
			end
			S_READ: cmd.rd_en = 1'b1;
			S_TEST: begin
				if (sts.op == OP_DELETE) begin
					cmd.cnt_dec = sts.hit && sts.idx_last;
					cmd.idx_inc = !sts.hit && !sts.idx_last;
				end else if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
					// older pending match goes out, not last
					cmd.pend_load = sts.hit;
					cmd.push      = sts.hit && sts.pend_valid;
					cmd.push_pend = 1'b1;
					cmd.idx_inc   = !sts.idx_last;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.push_pend   = sts.pend_valid;
					cmd.push_status = ST_NOTFOUND;
					cmd.push_last   = 1'b1;
					cmd.pend_clr    = 1'b1;
				end
			end
			S_SH_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
			end
			S_SH_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				cmd.cnt_dec  = sts.shift_last;
			end
			S_PUT: begin
				cmd.push      = sts.out_free;
				cmd.push_last = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	`RTSD_ASSERT_IMP(a_idle_no_pend, state_q == S_IDLE, !sts.pend_valid, "pending match left in idle")
	`RTSD_ASSERT_IMP(a_put_after_work, state_q == S_PUT, $past(state_q) != S_IDLE, "result without work")

endmodule

// File: design/rtsd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsd_dp
// Record table datapath: record memory, count, sweep index, output register.
// ----------------------------------------------------------------------------
`include "record_table_search_delete_defines.svh"

module rtsd_dp import rtsd_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = CNT_W + 1;

	record_t           mem [CAPACITY];
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	op_t               op_q;
	record_t           key_q;
	record_t           rd_data_q;
	logic              pend_valid_q;
	record_t           pend_q;
	logic              out_valid_q;
	status_t           out_status_q;
	record_t           out_rec_q;
	logic              out_last_q;

	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	record_t           wr_data;
	logic              wr_en;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(s_tuser);
			key_q <= record_t'(s_tdata[$bits(record_t)-1:0]);
		end
	end

	// Record memory, one write and one registered read port
	assign rd_addr = cmd.rd_next ? idx_q + IDX_W'(1) : idx_q;
	assign wr_en   = cmd.wr_ins || cmd.wr_shift;
	assign wr_addr = cmd.wr_ins ? IDX_W'(count_q) : idx_q;
	assign wr_data = cmd.wr_ins ? key_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_data_q <= mem[rd_addr];
	end

	// Entry count and sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.cnt_inc) count_q <= count_q + CNT_W'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CNT_W'(1);
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Held match, sent once the next match or the sweep end settles last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_valid_q <= 1'b0;
		else if (cmd.pend_load) pend_valid_q <= 1'b1;
		else if (cmd.pend_clr) pend_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_load) pend_q <= rd_data_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.push) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= cmd.push_pend ? ST_RECORD : cmd.push_status;
			out_rec_q    <= cmd.push_pend ? pend_q : '0;
			out_last_q   <= cmd.push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(record_t)){1'b0}}, out_rec_q};

	// Status to controller
	always_comb begin
		sts.op         = op_q;
		sts.cnt_zero   = (count_q == '0);
		sts.cnt_full   = (count_q == CNT_W'(CAPACITY));
		sts.idx_last   = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
		sts.shift_last = (EXT_W'(idx_q) + EXT_W'(2) == {1'b0, count_q});
		sts.hit        = (op_q == OP_LIST) ||
		                 ((rd_data_q.head == key_q.head) && (rd_data_q.tail == key_q.tail));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = !out_valid_q || m_tready;
	end

	`RTSD_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`RTSD_ASSERT_IMP(a_push_free, cmd.push, !out_valid_q || m_tready, "output word overwritten")
	`RTSD_ASSERT_IMP(a_dec_nonzero, cmd.cnt_dec, count_q != '0, "delete on empty table")

endmodule

// File: design/record_table_search_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_table_search_delete
// Bounded record table with insert, search, list and delete-with-compaction.
// ----------------------------------------------------------------------------
//  channel  dir  words per request      payload
//  s_*      in   1                      tuser: operation; tdata: request record
//  m_*      out  1 .. CAPACITY          tuser: status; tdata: record; tlast
//
//  Insert and empty-table requests go straight to the result; search, list
//  and delete sweep the record memory entry by entry (read, then compare),
//  and a delete moves each later entry down (read, then write).
//  Reset clears the entry count, sweep index, control state and valid flags;
//  the memory needs no clearing pass.
//  A new request is taken once the previous one has handed its last word to
//  the output register; a stalled output holds the sweep at the next match.
// ----------------------------------------------------------------------------
module record_table_search_delete import rtsd_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// name_head[63:0], name_tail[71:64], age[79:72], height[88:80]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_name_head[63:0], out_name_tail[71:64], out_age[79:72], out_height[88:80]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	cmd_t cmd;
	sts_t sts;

	rtsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtsd_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record table with insert, search, list and
// delete. A directed table walks the empty and full cases, duplicate and
// padding-only key differences and the longest delete shift; a random part
// drifts the table between empty and full with keys drawn from a small pool.
// Every output word is checked field by field against an in-bench table model.
// ----------------------------------------------------------------------------
module tb;
	import rtsd_pkg::*;

	localparam int CAP         = DEF_CAPACITY;
	localparam int WATCHDOG    = 2000;
	localparam int DRAIN       = 100;
	localparam int N_RANDOM    = 150;
	localparam int QUIET_TAIL  = 40;
	localparam int HOLD_CYCLES = 150;
	localparam int N_PLAN      = 19;
	localparam int N_KEYS      = 6;

	localparam logic [63:0] NAME_ALICE = 64'h414C_4943_4500_0000;
	localparam logic [63:0] NAME_BOB   = 64'h424F_4200_0000_0000;
	localparam logic [63:0] NAME_CAROL = 64'h4341_524F_4C00_0000;
	localparam logic [63:0] NAME_FILL  = 64'h4649_4C4C_3000_0000;

	// one expected output word
	typedef struct packed {
		status_t status;
		record_t rec;
		logic    last;
	} reply_t;

	// one row of the directed table
	typedef struct {
		op_t         op;
		logic [63:0] head;
		logic [7:0]  tail;
		logic [7:0]  age;
		logic [8:0]  height;
		int          reps;
		bit          typed;
		status_t     want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	record_t     book [CAP];
	int unsigned fill_level;
	reply_t      pending_replies [$];
	record_t     key_pool [N_KEYS];
	int          errors;
	int          quiet_cycles;
	bit          jitter_on;
	bit          hold_req;
	record_t     seen_rec;
	reply_t      due;

	record_table_search_delete dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void emit(status_t st, record_t rec, bit fin, bit keep);
		reply_t r;
		r.status = st;
		r.rec    = rec;
		r.last   = fin;
		if (keep)
			pending_replies.push_back(r);
	endfunction

	// Table model: updates the bench copy and queues the words it produces
	function automatic void serve_request(op_t op, record_t req, bit keep);
		int hit;
		int i;
		hit = -1;
		if (op == OP_INSERT) begin
			if (fill_level < CAP) begin
				book[fill_level] = req;
				fill_level++;
				emit(ST_INSERTED, '0, 1'b1, keep);
			end else begin
				emit(ST_FULL, '0, 1'b1, keep);
			end
		end else if (fill_level == 0) begin
			emit(ST_EMPTY, '0, 1'b1, keep);
		end else if (op == OP_SEARCH) begin
			// hold back each match until we know whether it is the final one
			for (i = 0; i < fill_level; i++) begin
				if (book[i].head == req.head && book[i].tail == req.tail) begin
					if (hit >= 0)
						emit(ST_RECORD, book[hit], 1'b0, keep);
					hit = i;
				end
			end
			if (hit >= 0)
				emit(ST_RECORD, book[hit], 1'b1, keep);
			else
				emit(ST_NOTFOUND, '0, 1'b1, keep);
		end else if (op == OP_LIST) begin
			for (i = 0; i < fill_level; i++)
				emit(ST_RECORD, book[i], i == fill_level - 1, keep);
		end else begin
			for (i = 0; i < fill_level && hit < 0; i++)
				if (book[i].head == req.head && book[i].tail == req.tail)
					hit = i;
			if (hit >= 0) begin
				for (i = hit; i + 1 < fill_level; i++)
					book[i] = book[i + 1];
				fill_level--;
				emit(ST_DELETED, '0, 1'b1, keep);
			end else begin
				emit(ST_NOTFOUND, '0, 1'b1, keep);
			end
		end
	endfunction

	// Present one request word and wait until it is taken
	task automatic offer(op_t op, record_t req, bit typed, status_t want);
		@(negedge clk);
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = IN_DATA_W'(req);
		do @(posedge clk); while (!s_tready);
		serve_request(op, req, !typed);
		if (typed)
			emit(want, '0, 1'b1, 1'b1);
	endtask

	// Output side: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (jitter_on && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Output check against the oldest expected word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected output word: status %0d", m_tuser);
				errors++;
			end else begin
				due      = pending_replies.pop_front();
				seen_rec = m_tdata[$bits(record_t)-1:0];
				if (m_tuser != due.status) begin
					$error("status: expected %0d, actual %0d", due.status, m_tuser);
					errors++;
				end
				if (seen_rec.head != due.rec.head) begin
					$error("out_name_head: expected %h, actual %h", due.rec.head, seen_rec.head);
					errors++;
				end
				if (seen_rec.tail != due.rec.tail) begin
					$error("out_name_tail: expected %h, actual %h", due.rec.tail, seen_rec.tail);
					errors++;
				end
				if (seen_rec.age != due.rec.age) begin
					$error("out_age: expected %0d, actual %0d", due.rec.age, seen_rec.age);
					errors++;
				end
				if (seen_rec.height != due.rec.height) begin
					$error("out_height: expected %0d, actual %0d", due.rec.height,
						seen_rec.height);
					errors++;
				end
				if (m_tlast != due.last) begin
					$error("last: expected %0d, actual %0d", due.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		step_t   plan [N_PLAN];
		record_t req;
		op_t     op;
		bit      filling;
		int      n;
		int      k;
		int      pick;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_INSERT;
		fill_level   = 0;
		errors       = 0;
		quiet_cycles = 0;
		jitter_on    = 1'b1;
		hold_req     = 1'b0;
		filling      = 1'b1;
		for (k = 0; k < CAP; k++)
			book[k] = '0;

		// directed table: empty cases, extremes, duplicates, fill to full,
		// padding-only mismatch, delete of the first entry (longest shift)
		plan[0]  = '{OP_LIST,   64'h0,      8'h00, 8'h00, 9'h000,  1, 1'b1, ST_EMPTY};
		plan[1]  = '{OP_SEARCH, NAME_ALICE, 8'h00, 8'h00, 9'h000,  1, 1'b1, ST_EMPTY};
		plan[2]  = '{OP_DELETE, NAME_ALICE, 8'h00, 8'h00, 9'h000,  1, 1'b1, ST_EMPTY};
		plan[3]  = '{OP_INSERT, '1,         8'hFF, 8'hFF, 9'h1FF,  1, 1'b1, ST_INSERTED};
		plan[4]  = '{OP_INSERT, 64'h0,      8'h00, 8'h00, 9'h000,  1, 1'b1, ST_INSERTED};
		plan[5]  = '{OP_INSERT, NAME_ALICE, 8'h00, 8'd30, 9'd165,  1, 1'b1, ST_INSERTED};
		plan[6]  = '{OP_INSERT, NAME_ALICE, 8'h00, 8'd41, 9'd170,  1, 1'b1, ST_INSERTED};
		plan[7]  = '{OP_INSERT, NAME_ALICE, 8'h01, 8'd7,  9'd99,   1, 1'b1, ST_INSERTED};
		plan[8]  = '{OP_INSERT, NAME_FILL,  8'h00, 8'd20, 9'd150, 11, 1'b1, ST_INSERTED};
		plan[9]  = '{OP_INSERT, NAME_CAROL, 8'h00, 8'd55, 9'd160,  1, 1'b1, ST_FULL};
		plan[10] = '{OP_SEARCH, NAME_ALICE, 8'h00, 8'h00, 9'h000,  1, 1'b0, ST_RECORD};
		plan[11] = '{OP_SEARCH, NAME_ALICE, 8'h01, 8'h00, 9'h000,  1, 1'b0, ST_RECORD};
		plan[12] = '{OP_SEARCH, NAME_BOB,   8'h00, 8'h00, 9'h000,  1, 1'b1, ST_NOTFOUND};
		plan[13] = '{OP_LIST,   64'h0,      8'h00, 8'h00, 9'h000,  1, 1'b0, ST_RECORD};
		plan[14] = '{OP_DELETE, NAME_ALICE, 8'h02, 8'h00, 9'h000,  1, 1'b1, ST_NOTFOUND};
		plan[15] = '{OP_DELETE, NAME_ALICE, 8'h00, 8'h00, 9'h000,  1, 1'b1, ST_DELETED};
		plan[16] = '{OP_DELETE, '1,         8'hFF, 8'h00, 9'h000,  1, 1'b1, ST_DELETED};
		plan[17] = '{OP_SEARCH, NAME_ALICE, 8'h00, 8'h00, 9'h000,  1, 1'b0, ST_RECORD};
		plan[18] = '{OP_LIST,   64'h0,      8'h00, 8'h00, 9'h000,  1, 1'b0, ST_RECORD};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < N_PLAN; n++) begin
			for (k = 0; k < plan[n].reps; k++) begin
				req.head   = plan[n].head + (64'(k) << 24);
				req.tail   = plan[n].tail;
				req.age    = plan[n].age + 8'(k);
				req.height = plan[n].height + 9'(k);
				offer(plan[n].op, req, plan[n].typed, plan[n].want);
			end
		end

		// key pool: near neighbors so matches and near misses are common
		key_pool[0].head = {$urandom, $urandom};
		key_pool[0].tail = 8'($urandom);
		key_pool[1]      = key_pool[0];
		key_pool[1].tail = key_pool[0].tail ^ 8'h01;
		key_pool[2]      = key_pool[0];
		key_pool[2].head = key_pool[0].head ^ 64'h8000_0000_0000_0000;
		key_pool[3].head = {$urandom, $urandom};
		key_pool[3].tail = 8'($urandom);
		key_pool[4].head = {8'($urandom), 56'h0};
		key_pool[4].tail = 8'h00;
		key_pool[5]      = '0;

		// long output hold-off while requests keep coming
		hold_req = 1'b1;

		for (n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - QUIET_TAIL)
				jitter_on = 1'b0;
			if (fill_level == CAP)
				filling = 1'b0;
			else if (fill_level == 0)
				filling = 1'b1;

			// drift toward full, then toward empty
			pick = $urandom_range(0, 99);
			if (filling)
				op = pick < 55 ? OP_INSERT : pick < 70 ? OP_SEARCH :
					pick < 80 ? OP_LIST : OP_DELETE;
			else
				op = pick < 15 ? OP_INSERT : pick < 35 ? OP_SEARCH :
					pick < 45 ? OP_LIST : OP_DELETE;

			pick = $urandom_range(0, 9);
			if (op != OP_INSERT && pick < 6 && fill_level > 0) begin
				req = book[$urandom_range(0, fill_level - 1)];
			end else if (pick < 9) begin
				req = key_pool[$urandom_range(0, N_KEYS - 1)];
			end else begin
				req.head = {$urandom, $urandom};
				req.tail = 8'($urandom);
			end
			req.age    = 8'($urandom);
			req.height = 9'($urandom);
			offer(op, req, 1'b0, ST_RECORD);
		end

		@(negedge clk);
		s_tvalid = 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0 && pending_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: record_table_search_delete.f
+incdir+design
design/rtsd_pkg.sv
design/rtsd_ctrl.sv
design/rtsd_dp.sv
design/record_table_search_delete.sv
verif/tb.sv
